/* rtl/core/lps_pkg.sv */
// ---------------------------------------------------------------------------
// lps_pkg
// shared types, register indexes and constants of the led strip pattern
// sequencer
// ---------------------------------------------------------------------------
package lps_pkg;

    localparam int STRIP_LENGTH_DEF = 144;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int TIME_W     = 16;
    localparam int STAMP_W    = 32;
    localparam int INDEX_W    = 8;
    localparam int CHAN_W     = 8;
    localparam int RGB_W      = 3 * CHAN_W;

    localparam logic [STAMP_W-1:0] PULSE_MS = 32'd100;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_TIME    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TIME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TIME = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME  = 3'd5;

    localparam logic [TIME_W-1:0] ON_TIME_RST    = 16'd200;
    localparam logic [TIME_W-1:0] OFF_TIME_RST   = 16'd200;
    localparam logic [TIME_W-1:0] PAUSE_TIME_RST = 16'd700;
    localparam logic [TIME_W-1:0] STEP_TIME_RST  = 16'd10;

    typedef enum logic [1:0] {
        PAT_SOLID = 2'd0,
        PAT_BLINK = 2'd1,
        PAT_HEART = 2'd2,
        PAT_SWEEP = 2'd3
    } pattern_t;

    typedef enum logic [2:0] {
        PH_UP0   = 3'd0,
        PH_DN0   = 3'd1,
        PH_UP1   = 3'd2,
        PH_DN1   = 3'd3,
        PH_PAUSE = 3'd4
    } heart_phase_t;

    typedef enum logic {
        ACT_FILL = 1'b0,
        ACT_SET  = 1'b1
    } action_t;

    typedef struct packed {
        pattern_t          pattern;
        logic [RGB_W-1:0]  color;
        logic [TIME_W-1:0] on_time;
        logic [TIME_W-1:0] off_time;
        logic [TIME_W-1:0] pause_time;
        logic [TIME_W-1:0] step_time;
    } lps_cfg_t;

    typedef struct packed {
        logic               emit;
        action_t            action;
        logic [INDEX_W-1:0] pixel_index;
        logic [RGB_W-1:0]   rgb;
    } lps_result_t;

endpackage

/* rtl/core/lps_cfg_regs.sv */
// ---------------------------------------------------------------------------
// lps_cfg_regs
// configuration register file; a pattern write raises a sequence clear
// ---------------------------------------------------------------------------
module lps_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0] cfg_data,
    output lps_pkg::lps_cfg_t             cfg,
    output logic                          seq_clear
);
    import lps_pkg::*;

    lps_cfg_t cfg_reg;
    lps_cfg_t cfg_next;
    logic     cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PATTERN:    cfg_next.pattern    = pattern_t'(cfg_data[1:0]);
                REG_COLOR:      cfg_next.color      = cfg_data[RGB_W-1:0];
                REG_ON_TIME:    cfg_next.on_time    = cfg_data[TIME_W-1:0];
                REG_OFF_TIME:   cfg_next.off_time   = cfg_data[TIME_W-1:0];
                REG_PAUSE_TIME: cfg_next.pause_time = cfg_data[TIME_W-1:0];
                REG_STEP_TIME:  cfg_next.step_time  = cfg_data[TIME_W-1:0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern    <= PAT_SOLID;
            cfg_reg.color      <= '0;
            cfg_reg.on_time    <= ON_TIME_RST;
            cfg_reg.off_time   <= OFF_TIME_RST;
            cfg_reg.pause_time <= PAUSE_TIME_RST;
            cfg_reg.step_time  <= STEP_TIME_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg       = cfg_reg;
    assign seq_clear = cfg_write && (cfg_index == REG_PATTERN);

endmodule

/* rtl/core/lps_engine.sv */
// ---------------------------------------------------------------------------
// lps_engine
// pattern sequence state and the per-tick command decision
// ---------------------------------------------------------------------------
module lps_engine #(
    parameter int STRIP_LENGTH = lps_pkg::STRIP_LENGTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        seq_clear,
    input  logic [lps_pkg::STAMP_W-1:0] now_ms,
    input  lps_pkg::lps_cfg_t           cfg,
    output lps_pkg::lps_result_t        res
);
    import lps_pkg::*;

    localparam int CNT_W = $clog2(STRIP_LENGTH + 1);
    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(STRIP_LENGTH);

    logic [STAMP_W-1:0] last_stamp_reg;
    logic [STAMP_W-1:0] last_stamp_next;
    logic               stamp_loaded_reg;
    logic               stamp_loaded_next;
    logic               lit_reg;
    logic               lit_next;
    heart_phase_t       heart_phase_reg;
    heart_phase_t       heart_phase_next;
    logic               sweep_started_reg;
    logic               sweep_started_next;
    logic [CNT_W-1:0]   pixel_count_reg;
    logic [CNT_W-1:0]   pixel_count_next;

    logic [STAMP_W-1:0]       base;
    logic [STAMP_W-1:0]       elapsed;
    logic                     gt_on;
    logic                     gt_off;
    logic                     gt_pulse;
    logic                     gt_pause;
    logic                     gt_step;
    logic [CNT_W-1:0]         count_inc;
    logic [CNT_W+INDEX_W-1:0] count_ext;

    // first tick after a clear takes its own stamp as the base
    assign base      = stamp_loaded_reg ? last_stamp_reg : now_ms;
    assign elapsed   = now_ms - base;
    assign gt_on     = elapsed > {{(STAMP_W-TIME_W){1'b0}}, cfg.on_time};
    assign gt_off    = elapsed > {{(STAMP_W-TIME_W){1'b0}}, cfg.off_time};
    assign gt_pulse  = elapsed > PULSE_MS;
    assign gt_pause  = elapsed > {{(STAMP_W-TIME_W){1'b0}}, cfg.pause_time};
    assign gt_step   = elapsed > {{(STAMP_W-TIME_W){1'b0}}, cfg.step_time};
    assign count_inc = pixel_count_reg + CNT_W'(1);
    assign count_ext = {{INDEX_W{1'b0}}, pixel_count_reg};

    // next state
    always_comb
    begin
        last_stamp_next    = last_stamp_reg;
        stamp_loaded_next  = stamp_loaded_reg;
        lit_next           = lit_reg;
        heart_phase_next   = heart_phase_reg;
        sweep_started_next = sweep_started_reg;
        pixel_count_next   = pixel_count_reg;
        if (seq_clear)
        begin
            last_stamp_next    = '0;
            stamp_loaded_next  = 1'b0;
            lit_next           = 1'b0;
            heart_phase_next   = PH_UP0;
            sweep_started_next = 1'b0;
            pixel_count_next   = '0;
        end
        else if (step)
        begin
            last_stamp_next   = base;
            stamp_loaded_next = 1'b1;
            unique case (cfg.pattern)
                PAT_SOLID:
                begin
                end
                PAT_BLINK:
                begin
                    if ((!lit_reg && gt_off) || (lit_reg && gt_on))
                    begin
                        last_stamp_next = now_ms;
                        lit_next        = !lit_reg;
                    end
                end
                PAT_HEART:
                begin
                    unique case (heart_phase_reg)
                        PH_UP0, PH_DN0, PH_UP1, PH_DN1:
                        begin
                            if (gt_pulse)
                            begin
                                last_stamp_next  = now_ms;
                                heart_phase_next = heart_phase_t'(heart_phase_reg + 3'd1);
                            end
                        end
                        PH_PAUSE:
                        begin
                            if (gt_pause)
                            begin
                                last_stamp_next  = now_ms;
                                heart_phase_next = PH_UP0;
                            end
                        end
                        default: heart_phase_next = PH_UP0;
                    endcase
                end
                PAT_SWEEP:
                begin
                    if (!sweep_started_reg)
                    begin
                        sweep_started_next = 1'b1;
                        pixel_count_next   = '0;
                    end
                    else if (gt_step)
                    begin
                        last_stamp_next  = now_ms;
                        pixel_count_next = count_inc;
                        if (count_inc >= LAST_COUNT)
                            sweep_started_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // command for this tick
    always_comb
    begin
        res.emit        = 1'b0;
        res.action      = ACT_FILL;
        res.pixel_index = '0;
        res.rgb         = '0;
        unique case (cfg.pattern)
            PAT_SOLID:
            begin
                res.emit = 1'b1;
                res.rgb  = cfg.color;
            end
            PAT_BLINK:
            begin
                if (!lit_reg && gt_off)
                begin
                    res.emit = 1'b1;
                    res.rgb  = cfg.color;
                end
                else if (lit_reg && gt_on)
                    res.emit = 1'b1;
            end
            PAT_HEART:
            begin
                unique case (heart_phase_reg)
                    PH_UP0, PH_UP1:
                    begin
                        res.emit = gt_pulse;
                        res.rgb  = cfg.color;
                    end
                    PH_DN0, PH_DN1: res.emit = gt_pulse;
                    PH_PAUSE:       res.emit = gt_pause;
                    default:        res.emit = 1'b0;
                endcase
            end
            PAT_SWEEP:
            begin
                if (!sweep_started_reg)
                    res.emit = 1'b1;
                else if (gt_step)
                begin
                    res.emit        = 1'b1;
                    res.action      = ACT_SET;
                    res.pixel_index = count_ext[INDEX_W-1:0];
                    res.rgb         = cfg.color;
                end
            end
            default: res.emit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_stamp_reg    <= '0;
            stamp_loaded_reg  <= 1'b0;
            lit_reg           <= 1'b0;
            heart_phase_reg   <= PH_UP0;
            sweep_started_reg <= 1'b0;
            pixel_count_reg   <= '0;
        end
        else
        begin
            last_stamp_reg    <= last_stamp_next;
            stamp_loaded_reg  <= stamp_loaded_next;
            lit_reg           <= lit_next;
            heart_phase_reg   <= heart_phase_next;
            sweep_started_reg <= sweep_started_next;
            pixel_count_reg   <= pixel_count_next;
        end
    end

    a_sweep_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_started_reg |-> (pixel_count_reg < LAST_COUNT))
        else $error("sweep pixel count past strip end");

    a_step_loads_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !seq_clear) |=> stamp_loaded_reg)
        else $error("stamp not loaded after a tick");

    a_clear_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
        seq_clear |=> (!stamp_loaded_reg && !lit_reg && !sweep_started_reg
                       && heart_phase_reg == PH_UP0))
        else $error("sequence state not cleared");

endmodule

/* rtl/core/led_strip_pattern_sequencer.sv */
// ---------------------------------------------------------------------------
// led_strip_pattern_sequencer
// time-stamped tick in, at most one strip fill or pixel-set command out
// ---------------------------------------------------------------------------
// an accepted tick waits in the input register; its command is then registered in the result register
// throughput: one tick per cycle while out_stall does not hold a full result register, set by
//   the input register and the combinational subtract/compare and registered state update of the engine
// ticks that produce no command still pass through the engine and update its state
// reset: rst_n clears all sequence state, empties both registers and loads
//   the register reset values; a pattern write also clears sequence state
module led_strip_pattern_sequencer #(
    parameter int STRIP_LENGTH = lps_pkg::STRIP_LENGTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lps_pkg::STAMP_W-1:0]    now_ms,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           action,
    output logic [lps_pkg::INDEX_W-1:0]    pixel_index,
    output logic [lps_pkg::CHAN_W-1:0]     red,
    output logic [lps_pkg::CHAN_W-1:0]     green,
    output logic [lps_pkg::CHAN_W-1:0]     blue,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lps_pkg::*;

    lps_cfg_t    cfg;
    logic        seq_clear;
    lps_result_t res;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [STAMP_W-1:0] now_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    lps_result_t        out_reg;
    logic               in_take;
    logic               advance;

    lps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .seq_clear (seq_clear)
    );

    lps_engine #(
        .STRIP_LENGTH (STRIP_LENGTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .seq_clear (seq_clear),
        .now_ms    (now_reg),
        .cfg       (cfg),
        .res       (res)
    );

    // held tick moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (advance)
            out_valid_next = res.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            now_reg <= now_ms;
        if (advance && res.emit)
            out_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign action      = out_reg.action;
    assign pixel_index = out_reg.pixel_index;
    assign red         = out_reg.rgb[3*CHAN_W-1:2*CHAN_W];
    assign green       = out_reg.rgb[2*CHAN_W-1:CHAN_W];
    assign blue        = out_reg.rgb[CHAN_W-1:0];

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while result path free");

    a_no_request_from_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |=> (!out_valid || $past(out_valid && out_stall)))
        else $error("command request without a tick");

    a_fill_has_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && action == ACT_FILL) |-> (pixel_index == '0))
        else $error("fill request with nonzero pixel index");

endmodule

/* test/led_strip_pattern_sequencer_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_strip_pattern_sequencer_tb
// drives time-stamped tick requests through the sequencer under all four
// patterns and changing register settings, predicts every strip command
// in-bench and compares each delivered command field by field, with random
// sender gaps and receiver stalls
// ---------------------------------------------------------------------------
module led_strip_pattern_sequencer_tb;

    import lps_pkg::*;

    localparam int STRIP_PIXELS = STRIP_LENGTH_DEF;
    localparam int PIPE_FLUSH   = 6;
    localparam logic [RGB_W-1:0] RGB_OFF = '0;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        action_t           action;
        logic [INDEX_W-1:0] pixel_index;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
    } strip_cmd_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [STAMP_W-1:0]    now_ms = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  action;
    logic [INDEX_W-1:0]    pixel_index;
    logic [CHAN_W-1:0]     red;
    logic [CHAN_W-1:0]     green;
    logic [CHAN_W-1:0]     blue;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predicted block state
    pattern_t           cur_pattern;
    logic [RGB_W-1:0]   cur_color;
    logic [TIME_W-1:0]  on_ms;
    logic [TIME_W-1:0]  off_ms;
    logic [TIME_W-1:0]  pause_ms;
    logic [TIME_W-1:0]  step_ms;
    logic [STAMP_W-1:0] last_stamp;
    bit                 stamp_loaded;
    bit                 lit;
    heart_phase_t       heart_phase;
    bit                 sweep_started;
    int                 pixel_count;

    strip_cmd_t pending_cmds[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;
    int ticks_sent = 0;
    int cmds_checked = 0;
    int cfg_writes = 0;

    led_strip_pattern_sequencer #(
        .STRIP_LENGTH(STRIP_PIXELS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .now_ms     (now_ms),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .action     (action),
        .pixel_index(pixel_index),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("%0t: timeout, %0d commands still outstanding", $time, pending_cmds.size());
        $display("Simulation FAILED");
        $finish;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic strip_cmd_t make_cmd(input action_t act, input logic [INDEX_W-1:0] idx,
                                            input logic [RGB_W-1:0] rgb);
        strip_cmd_t c;
        c.action      = act;
        c.pixel_index = (act == ACT_SET) ? idx : '0;
        c.red         = rgb[23:16];
        c.green       = rgb[15:8];
        c.blue        = rgb[7:0];
        return c;
    endfunction

    task automatic restart_sequence();
        last_stamp    = '0;
        stamp_loaded  = 1'b0;
        lit           = 1'b0;
        heart_phase   = PH_UP0;
        sweep_started = 1'b0;
        pixel_count   = 0;
    endtask

    // advance the predicted pattern by one tick, returns 1 when a command results
    function automatic bit pattern_step(input logic [STAMP_W-1:0] now, output strip_cmd_t cmd);
        logic [STAMP_W-1:0] elapsed;
        bit emits;
        emits = 1'b0;
        cmd = make_cmd(ACT_FILL, '0, RGB_OFF);
        if (!stamp_loaded)
        begin
            last_stamp   = now;
            stamp_loaded = 1'b1;
        end
        elapsed = now - last_stamp;
        case (cur_pattern)
            PAT_SOLID:
            begin
                emits = 1'b1;
                cmd = make_cmd(ACT_FILL, '0, cur_color);
            end
            PAT_BLINK:
            begin
                if (elapsed > {16'd0, (lit ? on_ms : off_ms)})
                begin
                    last_stamp = now;
                    lit = !lit;
                    emits = 1'b1;
                    cmd = make_cmd(ACT_FILL, '0, lit ? cur_color : RGB_OFF);
                end
            end
            PAT_HEART:
            begin
                case (heart_phase)
                    PH_UP0, PH_DN0, PH_UP1, PH_DN1:
                    begin
                        if (elapsed > PULSE_MS)
                        begin
                            last_stamp = now;
                            emits = 1'b1;
                            cmd = make_cmd(ACT_FILL, '0,
                                (heart_phase == PH_UP0 || heart_phase == PH_UP1) ?
                                cur_color : RGB_OFF);
                            heart_phase = heart_phase_t'(heart_phase + 3'd1);
                        end
                    end
                    PH_PAUSE:
                    begin
                        if (elapsed > {16'd0, pause_ms})
                        begin
                            last_stamp = now;
                            heart_phase = PH_UP0;
                            emits = 1'b1;
                        end
                    end
                    default:
                    begin
                        heart_phase = PH_UP0;
                    end
                endcase
            end
            default:
            begin
                if (!sweep_started)
                begin
                    // clearing fill, stamp left alone
                    sweep_started = 1'b1;
                    pixel_count = 0;
                    emits = 1'b1;
                end
                else if (elapsed > {16'd0, step_ms})
                begin
                    cmd = make_cmd(ACT_SET, pixel_count[INDEX_W-1:0], cur_color);
                    pixel_count++;
                    last_stamp = now;
                    if (pixel_count >= STRIP_PIXELS)
                    begin
                        sweep_started = 1'b0;
                    end
                    emits = 1'b1;
                end
            end
        endcase
        return emits;
    endfunction

    task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        error_count++;
    endtask

    always @(posedge clk)
    begin : result_check
        strip_cmd_t want;
        strip_cmd_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{action_t'(action), pixel_index, red, green, blue};
                cmds_checked++;
                if (pending_cmds.size() == 0)
                begin
                    $display("%0t: expected no command, actual action %0h index %0h rgb %h%h%h",
                             $time, got.action, got.pixel_index, got.red, got.green, got.blue);
                    error_count++;
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    if (got.action !== want.action)
                    begin
                        report_field("action", 8'(want.action), 8'(got.action));
                    end
                    if (got.pixel_index !== want.pixel_index)
                    begin
                        report_field("pixel_index", want.pixel_index, got.pixel_index);
                    end
                    if (got.red !== want.red)
                    begin
                        report_field("red", want.red, got.red);
                    end
                    if (got.green !== want.green)
                    begin
                        report_field("green", want.green, got.green);
                    end
                    if (got.blue !== want.blue)
                    begin
                        report_field("blue", want.blue, got.blue);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                ticks_sent++;
                if (pattern_step(now_ms, want))
                begin
                    pending_cmds.push_back(want);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PATTERN:
                    begin
                        cur_pattern = pattern_t'(cfg_data[1:0]);
                        restart_sequence();
                    end
                    REG_COLOR:      cur_color = cfg_data[RGB_W-1:0];
                    REG_ON_TIME:    on_ms = cfg_data[TIME_W-1:0];
                    REG_OFF_TIME:   off_ms = cfg_data[TIME_W-1:0];
                    REG_PAUSE_TIME: pause_ms = cfg_data[TIME_W-1:0];
                    REG_STEP_TIME:  step_ms = cfg_data[TIME_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        idle_pct  = (mode == IDLE_SENDER) ? 71 : (mode == IDLE_BOTH) ? 18 : 0;
        stall_pct = (mode == IDLE_RECEIVER) ? 71 : (mode == IDLE_BOTH) ? 18 : 0;
    endtask

    // drive one tick request and hold it until accepted
    task automatic send_tick(input logic [STAMP_W-1:0] stamp);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        now_ms <= stamp;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // wait until every predicted command has arrived and the pipe is empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge clk);
        repeat (PIPE_FLUSH) @(posedge clk);
    endtask

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return 16'($urandom_range(2, 300));
            4:       return 16'($urandom);
            default: return 16'd200;
        endcase
    endfunction

    function automatic logic [STAMP_W-1:0] next_delta();
        logic [STAMP_W-1:0] span;
        case (cur_pattern)
            PAT_BLINK: span = {16'd0, ((on_ms > off_ms) ? on_ms : off_ms)};
            PAT_HEART: span = ({16'd0, pause_ms} > PULSE_MS) ? {16'd0, pause_ms} : PULSE_MS;
            PAT_SWEEP: span = {16'd0, step_ms};
            default:   span = 32'd1000;
        endcase
        case ($urandom_range(0, 19))
            0:       return $urandom;
            1:       return 32'd0;
            2:       return span;
            3:       return span + 32'd1;
            4:       return PULSE_MS + 32'($urandom_range(0, 1));
            default: return $urandom_range(0, span / 2 + 2);
        endcase
    endfunction

    task automatic test_reset_values();
        set_idling(IDLE_NONE);
        send_tick(32'h0000_0000);
        send_tick(32'hFFFF_FFFF);
        settle();
        // blink on the reset dark time
        write_reg(REG_PATTERN, {22'd0, PAT_BLINK});
        send_tick(32'd1000);
        send_tick(32'd1200);
        send_tick(32'd1201);
    endtask

    task automatic test_solid_fill();
        settle();
        write_reg(REG_COLOR, 24'hFFFFFF);
        write_reg(REG_PATTERN, {22'h3FFFFF, PAT_SOLID});
        send_tick(32'h5555_5555);
        send_tick(32'hAAAA_AAAA);
    endtask

    task automatic test_blink_edges();
        settle();
        set_idling(IDLE_SENDER);
        write_reg(REG_ON_TIME, 24'hFF0000);
        write_reg(REG_OFF_TIME, 24'h000000);
        write_reg(REG_COLOR, 24'h123456);
        write_reg(REG_PATTERN, {22'd0, PAT_BLINK});
        // zero times across the stamp wrap
        send_tick(32'hFFFF_FFFE);
        send_tick(32'hFFFF_FFFE);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'h0000_0000);
    endtask

    task automatic test_heartbeat();
        logic [STAMP_W-1:0] b;
        b = 32'h8000_0000;
        settle();
        set_idling(IDLE_RECEIVER);
        write_reg(REG_PAUSE_TIME, 24'h00FFFF);
        write_reg(REG_COLOR, 24'hA5C30F);
        write_reg(REG_PATTERN, {22'd0, PAT_HEART});
        send_tick(b);
        send_tick(b + 32'd100);
        send_tick(b + 32'd101);
        send_tick(b + 32'd202);
        send_tick(b + 32'd303);
        send_tick(b + 32'd404);
        send_tick(b + 32'd404 + 32'd65535);
        send_tick(b + 32'd404 + 32'd65536);
    endtask

    task automatic test_sweep_steps();
        settle();
        set_idling(IDLE_BOTH);
        write_reg(REG_STEP_TIME, 24'h00FFFF);
        write_reg(REG_PATTERN, {22'd0, PAT_SWEEP});
        send_tick(32'h0000_1000);
        send_tick(32'h0000_1000 + 32'd65535);
        send_tick(32'h0000_1000 + 32'd65536);
    endtask

    task automatic test_unmapped_index();
        settle();
        set_idling(IDLE_NONE);
        write_reg(REG_PATTERN, {22'd0, PAT_SOLID});
        write_reg(REG_COLOR, 24'h00FF00);
        write_reg(REG_UNMAPPED_LO, 24'hFFFFFF);
        write_reg(REG_UNMAPPED_HI, 24'h000000);
        send_tick(32'h0F0F_0F0F);
    endtask

    task automatic test_sweep_wrap();
        logic [STAMP_W-1:0] stamp;
        settle();
        set_idling(IDLE_NONE);
        write_reg(REG_COLOR, 24'($urandom));
        write_reg(REG_STEP_TIME, {8'($urandom), 16'd0});
        write_reg(REG_PATTERN, {22'($urandom), PAT_SWEEP});
        stamp = $urandom;
        for (int i = 0; i < 170; i++)
        begin
            if (i == 85)
            begin
                set_idling(IDLE_BOTH);
            end
            stamp = stamp + 32'($urandom_range(0, 40));
            send_tick(stamp);
        end
    endtask

    task automatic test_random_mix();
        int seg;
        int sent;
        int n;
        logic [STAMP_W-1:0] stamp;
        seg = 0;
        sent = 0;
        while (sent < 680)
        begin
            settle();
            set_idling(idle_mode_t'(seg % 4));
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_COLOR, 24'($urandom));
            end
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_ON_TIME, {8'($urandom), pick_time()});
            end
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_OFF_TIME, {8'($urandom), pick_time()});
            end
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_PAUSE_TIME, {8'($urandom), pick_time()});
            end
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_STEP_TIME, {8'($urandom), pick_time()});
            end
            if ($urandom_range(0, 7) == 0)
            begin
                write_reg($urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                          24'($urandom));
            end
            // without a pattern write the running sequence carries on
            if ($urandom_range(0, 9) < 6)
            begin
                write_reg(REG_PATTERN, {22'($urandom), 2'($urandom)});
            end
            if ($urandom_range(0, 3) == 0)
            begin
                stamp = 32'hFFFF_FFFF - 32'($urandom_range(0, 2000));
            end
            else
            begin
                stamp = $urandom;
            end
            n = $urandom_range(60, 110);
            repeat (n)
            begin
                stamp = stamp + next_delta();
                send_tick(stamp);
            end
            sent += n;
            seg++;
        end
    endtask

    initial
    begin
        cur_pattern = PAT_SOLID;
        cur_color   = '0;
        on_ms       = ON_TIME_RST;
        off_ms      = OFF_TIME_RST;
        pause_ms    = PAUSE_TIME_RST;
        step_ms     = STEP_TIME_RST;
        restart_sequence();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_solid_fill();
        test_blink_edges();
        test_heartbeat();
        test_sweep_steps();
        test_unmapped_index();
        test_sweep_wrap();
        test_random_mix();
        settle();

        $display("run covered %0d ticks and %0d register writes over all four patterns,",
                 ticks_sent, cfg_writes);
        $display("%0d strip commands compared, %0d mismatches", cmds_checked, error_count);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/lps_pkg.sv
rtl/core/lps_cfg_regs.sv
rtl/core/lps_engine.sv
rtl/core/led_strip_pattern_sequencer.sv
test/led_strip_pattern_sequencer_tb.sv
